FILE: hdl/uaxr_pkg.sv
// Shared definitions for the oversampled UART with receive ring.
// Holds opcodes, register indexes, frame constants and interface structs.
// No dependencies.
package uaxr_pkg;

   localparam int RING_DEPTH_DEFAULT    = 256;
   localparam int TICKS_PER_BIT_DEFAULT = 3;

   localparam int RX_START_DELAY = 4;

   localparam logic [9:0] TX_IDLE_MARK = 10'h200;
   localparam logic [7:0] SKIP_CODE    = 8'hC2;
   localparam logic [7:0] LINE_FEED    = 8'h0A;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_SEND  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   localparam logic [1:0] CSR_RX_ENABLE       = 2'd0;
   localparam logic [1:0] CSR_RX_SAMPLE_COUNT = 2'd1;
   localparam logic [1:0] CSR_TX_FRAME_BITS   = 2'd2;

   typedef struct packed {
      logic tick;
      logic load;
   } tx_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rx_store_type;

endpackage

FILE: hdl/uaxr_ring.sv
// Receive ring storage: one write port and one registered read port.
// Depends on nothing but its parameters.
module uaxr_ring #(
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/uaxr_tx.sv
// Transmit shifter: loads a framed byte and shifts it out one bit per bit time.
// Depends on uaxr_pkg.
module uaxr_tx #(
   parameter int TICKS_PER_BIT = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  uaxr_pkg::tx_ctrl_type ctrl,
   input  logic [7:0]           tx_byte,
   input  logic [3:0]           frame_bits,
   output logic                 tx_level,
   output logic                 tx_active
);
   import uaxr_pkg::*;

   localparam int TW = $clog2(TICKS_PER_BIT + 1);

   logic [9:0]    shift_ff, shift_in;
   logic [TW-1:0] tick_cnt_ff, tick_cnt_in;
   logic [3:0]    bits_left_ff, bits_left_in;
   logic          active_ff, active_in;
   logic          level_ff, level_in;

   always_comb begin
      shift_in     = shift_ff;
      tick_cnt_in  = tick_cnt_ff;
      bits_left_in = bits_left_ff;
      active_in    = active_ff;
      level_in     = level_ff;
      if (ctrl.load) begin
         tick_cnt_in  = TW'(TICKS_PER_BIT);
         bits_left_in = frame_bits;
         shift_in     = {2'b00, tx_byte} << 1 | TX_IDLE_MARK;
         active_in    = 1'b1;
      end else if (ctrl.tick && active_ff) begin
         if (tick_cnt_ff <= TW'(1)) begin
            level_in    = shift_ff[0];
            shift_in    = shift_ff >> 1;
            tick_cnt_in = TW'(TICKS_PER_BIT);
            if (bits_left_ff <= 4'd1) begin
               bits_left_in = 4'd0;
               active_in    = 1'b0;
            end else begin
               bits_left_in = bits_left_ff - 4'd1;
            end
         end else begin
            tick_cnt_in = tick_cnt_ff - TW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         tick_cnt_ff  <= '0;
         bits_left_ff <= '0;
         active_ff    <= 1'b0;
         level_ff     <= 1'b1;
      end else begin
         shift_ff     <= shift_in;
         tick_cnt_ff  <= tick_cnt_in;
         bits_left_ff <= bits_left_in;
         active_ff    <= active_in;
         level_ff     <= level_in;
      end
   end

   assign tx_level  = level_ff;
   assign tx_active = active_ff;

endmodule

FILE: hdl/uaxr_rx.sv
// Receive sampler: detects the start level, samples data bits and requests a ring store.
// Depends on uaxr_pkg.
module uaxr_rx #(
   parameter int TICKS_PER_BIT = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   input  logic                   rx_line,
   input  logic                   enable,
   input  logic [3:0]             sample_count,
   output uaxr_pkg::rx_store_type store
);
   import uaxr_pkg::*;

   localparam int TMAX = (TICKS_PER_BIT > RX_START_DELAY) ? TICKS_PER_BIT : RX_START_DELAY;
   localparam int TW   = $clog2(TMAX + 1);

   logic          active_ff, active_in;
   logic          stop_wait_ff, stop_wait_in;
   logic [TW-1:0] tick_cnt_ff, tick_cnt_in;
   logic [3:0]    bits_left_ff, bits_left_in;
   logic [3:0]    bit_index_ff, bit_index_in;
   logic [7:0]    shift_ff, shift_in;

   always_comb begin
      active_in    = active_ff;
      stop_wait_in = stop_wait_ff;
      tick_cnt_in  = tick_cnt_ff;
      bits_left_in = bits_left_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      store.valid  = 1'b0;
      store.data   = shift_ff;
      if (tick && enable) begin
         if (stop_wait_ff) begin
            if (tick_cnt_ff <= TW'(1)) begin
               tick_cnt_in  = '0;
               stop_wait_in = 1'b0;
               active_in    = 1'b0;
               store.valid  = (shift_ff != SKIP_CODE);
            end else begin
               tick_cnt_in = tick_cnt_ff - TW'(1);
            end
         end else if (!active_ff) begin
            if (!rx_line) begin
               active_in    = 1'b1;
               shift_in     = '0;
               tick_cnt_in  = TW'(RX_START_DELAY);
               bits_left_in = sample_count;
               bit_index_in = '0;
            end
         end else if (tick_cnt_ff <= TW'(1)) begin
            tick_cnt_in = TW'(TICKS_PER_BIT);
            if (bit_index_ff < 4'd8) begin
               if (rx_line) begin
                  shift_in[bit_index_ff[2:0]] = 1'b1;
               end
               bit_index_in = bit_index_ff + 4'd1;
            end
            if (bits_left_ff <= 4'd1) begin
               bits_left_in = 4'd0;
               stop_wait_in = 1'b1;
            end else begin
               bits_left_in = bits_left_ff - 4'd1;
            end
         end else begin
            tick_cnt_in = tick_cnt_ff - TW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         stop_wait_ff <= 1'b0;
         tick_cnt_ff  <= '0;
         bits_left_ff <= '0;
         bit_index_ff <= '0;
         shift_ff     <= '0;
      end else begin
         active_ff    <= active_in;
         stop_wait_ff <= stop_wait_in;
         tick_cnt_ff  <= tick_cnt_in;
         bits_left_ff <= bits_left_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
      end
   end

endmodule

FILE: hdl/oversampled_uart_with_rx_ring_unit.sv
// Top level of the oversampled UART with receive ring.
// Depends on uaxr_pkg, uaxr_ring, uaxr_tx and uaxr_rx.
//
// This block is an 8N1 UART driven by a tick request at TICKS_PER_BIT times the baud
// rate, with received bytes kept in a RING_DEPTH-entry ring memory. Each request
// carries an opcode: tick (advance the transmitter and receiver by one tick, with
// the sampled receive level), send (load a byte into the transmitter, refused
// while a frame is in flight), read (pop the next byte, silently dropping line
// feeds and 0xC2, and reporting empty rather than waiting), or flush (clear both
// ring positions). Every request yields exactly one response that reports the
// transmit level, busy flag, send and read outcome, and whether unread bytes
// remain. Requests are handled one at a time. Tick, send and flush update the
// state and then load the response register, which waits while a held response
// is stalled. A read also pops ring entries one at a time, because the ring has
// a single registered read port and each popped entry must be examined before
// the next is fetched. The ring has no full check; the write position simply
// wraps over unread data. The ring needs no clearing pass after reset, since
// only entries that were written can ever be read. The register port is always
// ready; registers should be changed only while no request is pending.
module oversampled_uart_with_rx_ring_unit #(
   parameter int RING_DEPTH    = uaxr_pkg::RING_DEPTH_DEFAULT,
   parameter int TICKS_PER_BIT = uaxr_pkg::TICKS_PER_BIT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_tx_byte,
   input  logic       req_rx_line,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_line,
   output logic       rsp_tx_busy,
   output logic       rsp_send_accepted,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_rx_available,
   // Register write port.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data
);
   import uaxr_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
      return (pos == AW'(RING_DEPTH - 1)) ? '0 : pos + AW'(1);
   endfunction

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] wr_pos_ff, wr_pos_in;
   logic [AW-1:0] rd_pos_ff, rd_pos_in;
   logic          accepted_ff, accepted_in;
   logic          got_valid_ff, got_valid_in;
   logic [7:0]    got_byte_ff, got_byte_in;

   logic          rx_enable_ff;
   logic [3:0]    rx_sample_count_ff;
   logic [3:0]    tx_frame_bits_ff;

   logic          rsp_valid_ff;
   logic          rsp_tx_line_ff, rsp_tx_busy_ff, rsp_accepted_ff;
   logic          rsp_read_valid_ff, rsp_rx_available_ff;
   logic [7:0]    rsp_read_byte_ff;

   logic          req_take;
   logic          rsp_load;
   logic          mem_rd_en;
   logic [7:0]    mem_rd_data;
   tx_ctrl_type   tx_ctrl;
   rx_store_type  rx_store;
   logic          tx_level, tx_active;
   logic          rx_tick;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rx_tick   = req_take && (req_opcode == OP_TICK);
   assign csr_ready = 1'b1;

   // Sequencer: runs one request, walks the ring on a read, then loads the response.
   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      accepted_in  = accepted_ff;
      got_valid_in = got_valid_ff;
      got_byte_in  = got_byte_ff;
      tx_ctrl      = '0;
      mem_rd_en    = 1'b0;
      rsp_load     = 1'b0;

      if (rx_store.valid) begin
         wr_pos_in = ring_next(wr_pos_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               accepted_in  = 1'b0;
               got_valid_in = 1'b0;
               got_byte_in  = '0;
               state_in     = ST_OUT;
               case (req_opcode)
                  OP_TICK: begin
                     tx_ctrl.tick = 1'b1;
                  end
                  OP_SEND: begin
                     if (!tx_active) begin
                        tx_ctrl.load = 1'b1;
                        accepted_in  = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (rd_pos_ff != wr_pos_ff) begin
                        mem_rd_en = 1'b1;
                        rd_pos_in = ring_next(rd_pos_ff);
                        state_in  = ST_READ;
                     end
                  end
                  default: begin
                     wr_pos_in = '0;
                     rd_pos_in = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            // The byte fetched last cycle is on the read port now.
            if (mem_rd_data != LINE_FEED && mem_rd_data != SKIP_CODE) begin
               got_valid_in = 1'b1;
               got_byte_in  = mem_rd_data;
               state_in     = ST_OUT;
            end else if (rd_pos_ff == wr_pos_ff) begin
               state_in = ST_OUT;
            end else begin
               mem_rd_en = 1'b1;
               rd_pos_in = ring_next(rd_pos_ff);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         accepted_ff  <= 1'b0;
         got_valid_ff <= 1'b0;
         got_byte_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         accepted_ff  <= accepted_in;
         got_valid_ff <= got_valid_in;
         got_byte_ff  <= got_byte_in;
      end
   end

   // Configuration registers; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff       <= 1'b1;
         rx_sample_count_ff <= 4'd10;
         tx_frame_bits_ff   <= 4'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RX_ENABLE:       rx_enable_ff       <= csr_data[0];
            CSR_RX_SAMPLE_COUNT: rx_sample_count_ff <= csr_data;
            CSR_TX_FRAME_BITS:   tx_frame_bits_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Response register. In ST_OUT every state register already holds the
   // post-request value, so the status fields are taken straight from them.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tx_line_ff      <= tx_level;
         rsp_tx_busy_ff      <= tx_active;
         rsp_accepted_ff     <= accepted_ff;
         rsp_read_valid_ff   <= got_valid_ff;
         rsp_read_byte_ff    <= got_byte_ff;
         rsp_rx_available_ff <= (rd_pos_ff != wr_pos_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_line       = rsp_tx_line_ff;
   assign rsp_tx_busy       = rsp_tx_busy_ff;
   assign rsp_send_accepted = rsp_accepted_ff;
   assign rsp_read_valid    = rsp_read_valid_ff;
   assign rsp_read_byte     = rsp_read_byte_ff;
   assign rsp_rx_available  = rsp_rx_available_ff;

   uaxr_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (rx_store.valid),
      .wr_addr (wr_pos_ff),
      .wr_data (rx_store.data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_pos_ff),
      .rd_data (mem_rd_data)
   );

   uaxr_tx #(
      .TICKS_PER_BIT (TICKS_PER_BIT)
   ) u_tx (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (tx_ctrl),
      .tx_byte    (req_tx_byte),
      .frame_bits (tx_frame_bits_ff),
      .tx_level   (tx_level),
      .tx_active  (tx_active)
   );

   uaxr_rx #(
      .TICKS_PER_BIT (TICKS_PER_BIT)
   ) u_rx (
      .clock        (clock),
      .reset        (reset),
      .tick         (rx_tick),
      .rx_line      (req_rx_line),
      .enable       (rx_enable_ff),
      .sample_count (rx_sample_count_ff),
      .store        (rx_store)
   );

endmodule
